@@ hw/rtl/hlbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbp_pkg
// shared types and constants of the history lru branch predictor
// ----------------------------------------------------------------------------
package hlbp_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int CNT_W      = 4;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cfg_idx_t REG_HISTORY_BITS   = 1'd0;
  localparam cfg_idx_t REG_COUNTER_STATES = 1'd1;

  localparam cfg_data_t HISTORY_BITS_RST   = 5'd4;
  localparam cfg_data_t COUNTER_STATES_RST = 5'd4;
  localparam cfg_data_t STATES_MIN         = 5'd2;
  localparam cfg_data_t STATES_MAX         = 5'd16;

endpackage

@@ hw/rtl/history_lru_branch_predictor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_lru_branch_predictor
// global history predictor with a fully associative lru pattern table
// ----------------------------------------------------------------------------
// usage
//   input beat : in_taken is taken when start is high and busy is low; one
//                beat may be taken in every clock cycle
//   result beat: out_predicted_taken is shown for one cycle with out_valid;
//                the receiver cannot stall, every strobe is a delivered beat
//   config     : cfg_valid/cfg_ready write cfg_data into register cfg_index
//                (0 history_bits, 1 counter_states); cfg_ready is always high
//                and the user makes writes only while no beat is in flight,
//                which the block itself does not enforce
//   path       : beat -> in_vld_r/in_taken_r -> out_valid_r/out_pred_r
//   throughput : one beat per cycle; the table lookup, lru update and counter
//                update of a beat happen together in the same cycle, so the
//                next beat sees the updated table
//   reset      : rst_n low clears history, table valid bits, ages and the
//                pipeline; busy is high while reset is held
// ----------------------------------------------------------------------------
module history_lru_branch_predictor
  import hlbp_pkg::*;
#(
  parameter int TABLE_ENTRIES    = 16,
  parameter int MAX_HISTORY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  logic      in_taken,
  output logic      out_valid,
  output logic      out_predicted_taken,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;

  typedef logic [MAX_HISTORY_BITS-1:0] hist_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [RANK_W-1:0]           rank_t;

  // configuration
  cfg_data_t hist_bits_r;
  cfg_data_t cnt_states_r;

  // input stage
  logic in_vld_r;
  logic in_taken_r;

  // table and history
  hist_t                     hist_r;
  logic [TABLE_ENTRIES-1:0]  valid_r;
  rank_t                     rank_r [TABLE_ENTRIES];
  hist_t                     key_r  [TABLE_ENTRIES];
  cnt_t                      cnt_r  [TABLE_ENTRIES];

  // result stage
  logic out_valid_r;
  logic out_pred_r;

  // lookup
  logic      hit;
  logic      free;
  idx_t      hit_idx;
  idx_t      free_idx;
  idx_t      old_idx;
  idx_t      slot;
  rank_t     hit_rank;
  cnt_t      hit_cnt;
  cfg_data_t hb_eff;
  cfg_data_t sc_eff;
  cfg_data_t sc_m1;
  cnt_t      half;
  cnt_t      cnt_cur;
  cnt_t      cnt_nxt;
  logic      pred;
  hist_t     mask;
  hist_t     hist_nxt;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_bits_r  <= HISTORY_BITS_RST;
      cnt_states_r <= COUNTER_STATES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HISTORY_BITS:   hist_bits_r  <= cfg_data;
        REG_COUNTER_STATES: cnt_states_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_taken_r <= in_taken;
    end
  end

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    hit_rank = '0;
    hit_cnt  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == hist_r) begin
        hit      = 1'b1;
        hit_idx  = IDX_W'(i);
        hit_rank = rank_r[i];
        hit_cnt  = cnt_r[i];
      end
      if (!valid_r[i]) begin
        free     = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (valid_r[i] && rank_r[i] == RANK_W'(TABLE_ENTRIES - 1)) begin
        old_idx = IDX_W'(i);
      end
    end
    slot = hit ? hit_idx : (free ? free_idx : old_idx);
  end

  // clamped configuration
  always_comb begin
    if (hist_bits_r < 5'd1) begin
      hb_eff = 5'd1;
    end else if (hist_bits_r > 5'(MAX_HISTORY_BITS)) begin
      hb_eff = 5'(MAX_HISTORY_BITS);
    end else begin
      hb_eff = hist_bits_r;
    end
    if (cnt_states_r < STATES_MIN) begin
      sc_eff = STATES_MIN;
    end else if (cnt_states_r > STATES_MAX) begin
      sc_eff = STATES_MAX;
    end else begin
      sc_eff = cnt_states_r;
    end
    for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
      mask[i] = (5'(i) < hb_eff);
    end
  end

  // counter and history update
  always_comb begin
    sc_m1   = sc_eff - 5'd1;
    half    = CNT_W'(sc_eff >> 1);
    cnt_cur = hit ? hit_cnt : half;
    pred    = cnt_cur > half;
    cnt_nxt = cnt_cur;
    if (in_taken_r) begin
      if ({1'b0, cnt_cur} < sc_m1) begin
        cnt_nxt = cnt_cur + CNT_W'(1);
      end
    end else begin
      if (cnt_cur != '0) begin
        cnt_nxt = cnt_cur - CNT_W'(1);
      end
    end
    hist_nxt = ((hist_r << 1) & mask) | hist_t'(in_taken_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      valid_r <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (in_vld_r) begin
      hist_r <= hist_nxt;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && (!hit || rank_r[i] < hit_rank)) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          cnt_r[i] <= cnt_nxt;
          if (!hit) begin
            key_r[i] <= hist_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_pred_r <= pred;
    end
  end

endmodule
